// File: rtl/sss_pkg.sv
package sss_pkg;

  // Default depths for the interning cache and the scope stack
  localparam int CACHE_SLOTS_DEF = 32;
  localparam int STACK_DEPTH_DEF = 64;

  // Fixed result field widths
  localparam int SLOT_W = 5;
  localparam int MARK_W = 7;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_FIND,
    OP_SAVE,
    OP_RESTORE,
    OP_HIDE,
    OP_UNHIDE,
    OP_REWIND,
    OP_COUNT
  } op_e;

  typedef struct packed {
    op_e                opcode;
    logic [7:0]         name_char;
    logic [15:0]        position;
    logic [MARK_W-1:0]  saved_mark;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [SLOT_W-1:0]  slot;
    logic [15:0]        slot_position;
    logic [MARK_W-1:0]  mark;
    logic               overflow;
  } out_item_t;

  // One interning cache entry
  typedef struct packed {
    logic [7:0]  letter;
    logic [15:0] pos;
  } slot_rec_t;

endpackage

// File: rtl/scoped_symbol_stack_top.sv
// Channel | Signals                            | Direction
// --------+------------------------------------+----------
// input   | in_valid_i, in_ready_o, in_item_i  | in
// result  | out_valid_o, out_ready_i, out_item_o | out
//
// One item at a time: a new input is taken only once the last result is in the output register.
// push scans the cache (one cache read per cycle), except on a full stack;
// find scans the window from its start (scope read then cache read,
// one entry per cycle); every other opcode goes straight to the result.
// Reset clears the control registers only; cache and stack memories hold garbage until written.
// A stalled result sits in the output register; the next item is taken meanwhile.
module scoped_symbol_stack_top #(
  parameter int CACHE_SLOTS = sss_pkg::CACHE_SLOTS_DEF,
  parameter int STACK_DEPTH = sss_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sss_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sss_pkg::out_item_t out_item_o
);
  import sss_pkg::*;

  localparam int SW = $clog2(CACHE_SLOTS);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int UW = $clog2(CACHE_SLOTS + 1);
  localparam int TW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (TW > UW) ? TW : UW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [7:0]       key_q, key_d;
  logic [15:0]      pos_q, pos_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [IW-1:0]    lim_q, lim_d;
  logic             vld1_q, vld1_d;
  logic             vld2_q, vld2_d;
  logic [SW-1:0]    s2_q, s2_d;
  logic [UW-1:0]    used_q, used_d;
  logic [TW-1:0]    top_q, top_d;
  logic [TW-1:0]    ws_q, ws_d;
  out_item_t        res_q, res_d;
  out_item_t        out_q, out_d;
  logic             out_vld_q, out_vld_d;

  // Cache memory: letter and creation position
  slot_rec_t        slot_mem [CACHE_SLOTS];
  slot_rec_t        slot_rd_q;
  logic [SW-1:0]    slot_raddr;
  logic             slot_we;
  logic [SW-1:0]    slot_waddr;
  slot_rec_t        slot_wdata;

  // Scope stack memory: slot indices
  logic [SW-1:0]    scope_mem [STACK_DEPTH];
  logic [SW-1:0]    scope_rd_q;
  logic [AW-1:0]    scope_raddr;
  logic             scope_we;
  logic [AW-1:0]    scope_waddr;
  logic [SW-1:0]    scope_wdata;

  logic             issue;
  logic             match;
  logic             scan_miss;
  logic [TW-1:0]    clamp_mark;

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (scope_we) begin
      scope_mem[scope_waddr] <= scope_wdata;
    end
    scope_rd_q <= scope_mem[scope_raddr];
  end

  // Find walks the stack, then looks the slot up; push walks the cache directly
  assign scope_raddr = idx_q[AW-1:0];
  assign slot_raddr  = (op_q == OP_FIND) ? scope_rd_q : idx_q[SW-1:0];

  assign issue     = (state_q == ST_SCAN) && (idx_q < lim_q);
  assign match     = vld2_q && (slot_rd_q.letter == key_q);
  assign scan_miss = !match && !(idx_q < lim_q) && !vld1_q;

  assign clamp_mark = (32'(in_item_i.saved_mark) > 32'(STACK_DEPTH)) ?
                      TW'(STACK_DEPTH) : TW'(in_item_i.saved_mark);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    lim_d       = lim_q;
    vld1_d      = 1'b0;
    vld2_d      = 1'b0;
    s2_d        = s2_q;
    used_d      = used_q;
    top_d       = top_q;
    ws_d        = ws_q;
    res_d       = res_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    slot_we     = 1'b0;
    slot_waddr  = used_q[SW-1:0];
    slot_wdata  = '{letter: key_q, pos: pos_q};
    scope_we    = 1'b0;
    scope_waddr = top_q[AW-1:0];
    scope_wdata = s2_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_item_i.opcode;
          key_d   = in_item_i.name_char;
          pos_d   = in_item_i.position;
          res_d   = '0;
          state_d = ST_DONE;
          case (in_item_i.opcode)
            OP_PUSH: begin
              if (top_q >= TW'(STACK_DEPTH)) begin
                res_d.overflow = 1'b1;
              end else begin
                idx_d   = '0;
                lim_d   = IW'(used_q);
                state_d = ST_SCAN;
              end
            end
            OP_FIND: begin
              idx_d   = IW'(ws_q);
              lim_d   = IW'(top_q);
              state_d = ST_SCAN;
            end
            OP_SAVE: begin
              res_d.mark = MARK_W'(top_q);
            end
            OP_RESTORE: begin
              top_d = clamp_mark;
            end
            OP_HIDE: begin
              res_d.mark = MARK_W'(ws_q);
              ws_d       = top_q;
            end
            OP_UNHIDE: begin
              top_d = ws_q;
              ws_d  = clamp_mark;
            end
            OP_REWIND: begin
              top_d = '0;
              ws_d  = '0;
            end
            OP_COUNT: begin
              res_d.mark = (top_q > ws_q) ? MARK_W'(top_q - ws_q) : '0;
            end
            default: begin
              res_d = '0;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Read pipeline, oldest entry compared first
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (op_q == OP_FIND) begin
          vld1_d = issue;
          vld2_d = vld1_q;
          s2_d   = scope_rd_q;
        end else begin
          vld2_d = issue;
          s2_d   = idx_q[SW-1:0];
        end

        if (match) begin
          res_d.found         = 1'b1;
          res_d.slot          = SLOT_W'(s2_q);
          res_d.slot_position = slot_rd_q.pos;
          if (op_q == OP_PUSH) begin
            scope_we    = 1'b1;
            scope_wdata = s2_q;
            top_d       = top_q + 1'b1;
          end
          vld1_d  = 1'b0;
          vld2_d  = 1'b0;
          state_d = ST_DONE;
        end else if (scan_miss) begin
          if (op_q == OP_PUSH) begin
            if (used_q >= UW'(CACHE_SLOTS)) begin
              res_d.overflow = 1'b1;
            end else begin
              // New letter: intern it and push its slot
              slot_we             = 1'b1;
              scope_we            = 1'b1;
              scope_wdata         = used_q[SW-1:0];
              used_d              = used_q + 1'b1;
              top_d               = top_q + 1'b1;
              res_d.found         = 1'b1;
              res_d.slot          = SLOT_W'(used_q);
              res_d.slot_position = pos_q;
            end
          end
          vld1_d  = 1'b0;
          vld2_d  = 1'b0;
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_PUSH;
      key_q     <= '0;
      pos_q     <= '0;
      idx_q     <= '0;
      lim_q     <= '0;
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      s2_q      <= '0;
      used_q    <= '0;
      top_q     <= '0;
      ws_q      <= '0;
      res_q     <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      key_q     <= key_d;
      pos_q     <= pos_d;
      idx_q     <= idx_d;
      lim_q     <= lim_d;
      vld1_q    <= vld1_d;
      vld2_q    <= vld2_d;
      s2_q      <= s2_d;
      used_q    <= used_d;
      top_q     <= top_d;
      ws_q      <= ws_d;
      res_q     <= res_d;
      out_q     <= out_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// File: rtl/sss_checker.sv
module sss_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input sss_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sss_pkg::out_item_t out_item_o
);
  import sss_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // One item in flight: no transfer in the cycle after one
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is still in work");

  // A refused push carries nothing else
  a_ovf_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.overflow |->
      !out_item_o.found && (out_item_o.slot == '0) &&
      (out_item_o.slot_position == '0) && (out_item_o.mark == '0))
    else $error("overflow result with stray fields");

  // A slot answer carries no mark
  a_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.found |-> (out_item_o.mark == '0))
    else $error("found result with nonzero mark");

endmodule

bind scoped_symbol_stack_top sss_checker u_sss_checker (.*);

// File: test/tb_scoped_symbol_stack_top.sv
module tb_scoped_symbol_stack_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sss_pkg::*;

  localparam int CACHE_SLOTS  = CACHE_SLOTS_DEF;
  localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 80;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  // When set, neither side inserts idle cycles
  logic steady;

  int unsigned cycle_count;
  int unsigned err_count;

  // Shadow copy of the symbol table
  logic [7:0]        letter_of_slot [CACHE_SLOTS];
  logic [15:0]       pos_of_slot    [CACHE_SLOTS];
  int                slots_taken;
  logic [SLOT_W-1:0] scope_slot     [STACK_DEPTH];
  int                scope_base;
  int                scope_top;
  int                scope_written;  // entries 0 .. scope_written-1 hold known slots

  // Replies still owed by the block, oldest first
  out_item_t symbol_replies [$];

  // Marks handed out by save and hide, reused by restore and unhide
  logic [MARK_W-1:0] saved_tops [$];
  logic [MARK_W-1:0] hidden_bases [$];

  scoped_symbol_stack_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side backpressure
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 15);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Compute the reply for one operation and advance the shadow table
  function automatic out_item_t apply_symbol_op(input in_item_t it);
    out_item_t r;
    int        hit;
    int        m;
    r = '0;
    case (it.opcode)
      OP_PUSH: begin
        hit = -1;
        if (scope_top >= STACK_DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          for (int i = 0; i < slots_taken; i++) begin
            if (hit < 0 && letter_of_slot[i] == it.name_char) hit = i;
          end
          if (hit < 0 && slots_taken >= CACHE_SLOTS) begin
            r.overflow = 1'b1;
          end else begin
            if (hit < 0) begin
              hit = slots_taken;
              letter_of_slot[hit] = it.name_char;
              pos_of_slot[hit]    = it.position;
              slots_taken++;
            end
            scope_slot[scope_top] = hit[SLOT_W-1:0];
            scope_top++;
            if (scope_top > scope_written) scope_written = scope_top;
            r.found         = 1'b1;
            r.slot          = hit[SLOT_W-1:0];
            r.slot_position = pos_of_slot[hit];
          end
        end
      end
      OP_FIND: begin
        hit = -1;
        for (int i = scope_base; i < scope_top && i < STACK_DEPTH; i++) begin
          if (hit < 0 && letter_of_slot[scope_slot[i]] == it.name_char)
            hit = int'(scope_slot[i]);
        end
        if (hit >= 0) begin
          r.found         = 1'b1;
          r.slot          = hit[SLOT_W-1:0];
          r.slot_position = pos_of_slot[hit];
        end
      end
      OP_SAVE: r.mark = scope_top[MARK_W-1:0];
      OP_RESTORE: begin
        m = int'(it.saved_mark);
        scope_top = (m > STACK_DEPTH) ? STACK_DEPTH : m;
      end
      OP_HIDE: begin
        r.mark     = scope_base[MARK_W-1:0];
        scope_base = scope_top;
      end
      OP_UNHIDE: begin
        m          = int'(it.saved_mark);
        scope_top  = scope_base;
        scope_base = (m > STACK_DEPTH) ? STACK_DEPTH : m;
      end
      OP_REWIND: begin
        scope_base = 0;
        scope_top  = 0;
      end
      default: begin
        m      = (scope_top > scope_base) ? scope_top - scope_base : 0;
        r.mark = m[MARK_W-1:0];
      end
    endcase
    return r;
  endfunction

  // One input transfer; the reply is predicted at acceptance
  task automatic send_op(input op_e op, input logic [7:0] letter, input logic [15:0] pos,
                         input logic [MARK_W-1:0] mark);
    in_item_t it;
    int       gap;
    it.opcode     = op;
    it.name_char  = letter;
    it.position   = pos;
    it.saved_mark = mark;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 15) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    symbol_replies.push_back(apply_symbol_op(it));
  endtask

  // Mark that never exposes an unwritten stack entry
  function automatic logic [MARK_W-1:0] pick_mark();
    if (scope_written == STACK_DEPTH && $urandom_range(0, 9) == 0)
      return MARK_W'($urandom_range(STACK_DEPTH + 1, 127));
    return MARK_W'($urandom_range(0, scope_written));
  endfunction

  // Mostly letters already interned, now and then any byte
  function automatic logic [7:0] pick_letter();
    if (slots_taken > 0 && $urandom_range(0, 99) < 92)
      return letter_of_slot[$urandom_range(0, slots_taken - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] fresh_letter();
    logic [7:0] c;
    logic       taken;
    do begin
      c     = 8'($urandom_range(0, 255));
      taken = 1'b0;
      for (int i = 0; i < slots_taken; i++) if (letter_of_slot[i] == c) taken = 1'b1;
    end while (taken);
    return c;
  endfunction

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (symbol_replies.size() == 0) begin
        report_mismatch("unexpected result", int'(out_item), 0);
      end else begin
        want = symbol_replies.pop_front();
        if (out_item.found != want.found)
          report_mismatch("found", int'(out_item.found), int'(want.found));
        if (out_item.slot != want.slot)
          report_mismatch("slot", int'(out_item.slot), int'(want.slot));
        if (out_item.slot_position != want.slot_position)
          report_mismatch("slot_position", int'(out_item.slot_position),
                          int'(want.slot_position));
        if (out_item.mark != want.mark)
          report_mismatch("mark", int'(out_item.mark), int'(want.mark));
        if (out_item.overflow != want.overflow)
          report_mismatch("overflow", int'(out_item.overflow), int'(want.overflow));
      end
    end
  end

  // Field extremes, reuse of a known letter, hidden and empty windows
  task automatic test_scope_basics();
    send_op(OP_PUSH,    8'h00, 16'hFFFF, 7'd0);
    send_op(OP_PUSH,    8'hFF, 16'h0000, 7'd0);
    send_op(OP_PUSH,    8'h00, 16'h1234, 7'd0);  // known letter, position ignored
    send_op(OP_FIND,    8'hFF, 16'h0000, 7'd0);
    send_op(OP_FIND,    8'h55, 16'hFFFF, 7'd0);  // miss
    send_op(OP_SAVE,    8'h00, 16'h0000, 7'd0);
    send_op(OP_HIDE,    8'h00, 16'h0000, 7'd0);
    send_op(OP_PUSH,    8'h41, 16'h8000, 7'd0);
    send_op(OP_FIND,    8'h00, 16'h0000, 7'd0);  // below the window
    send_op(OP_FIND,    8'h41, 16'h0000, 7'd0);
    send_op(OP_COUNT,   8'h00, 16'h0000, 7'd0);
    send_op(OP_UNHIDE,  8'h00, 16'h0000, 7'd1);
    send_op(OP_FIND,    8'hFF, 16'h0000, 7'd0);
    send_op(OP_COUNT,   8'h00, 16'h0000, 7'd0);
    send_op(OP_HIDE,    8'h00, 16'h0000, 7'd0);
    send_op(OP_UNHIDE,  8'h00, 16'h0000, 7'd4);  // start lands above top
    send_op(OP_FIND,    8'h41, 16'h0000, 7'd0);
    send_op(OP_COUNT,   8'h00, 16'h0000, 7'd0);
    send_op(OP_RESTORE, 8'h00, 16'h0000, 7'd0);
    send_op(OP_REWIND,  8'h00, 16'h0000, 7'd0);
    send_op(OP_COUNT,   8'h00, 16'h0000, 7'd0);
  endtask

  // Fill the stack, push past it, then clamp marks beyond the depth
  task automatic test_stack_overflow();
    send_op(OP_REWIND, 8'h00, 16'h0000, 7'd0);
    while (scope_top < STACK_DEPTH)
      send_op(OP_PUSH, pick_letter(), 16'($urandom), 7'd0);
    send_op(OP_PUSH,    pick_letter(), 16'hFFFF, 7'd0);
    send_op(OP_PUSH,    fresh_letter(), 16'h0000, 7'd0);
    send_op(OP_SAVE,    8'h00, 16'h0000, 7'd0);
    send_op(OP_FIND,    pick_letter(), 16'h0000, 7'd0);
    send_op(OP_RESTORE, 8'h00, 16'h0000, 7'd127);
    send_op(OP_SAVE,    8'h00, 16'h0000, 7'd0);
    send_op(OP_UNHIDE,  8'h00, 16'h0000, 7'd100);
    send_op(OP_COUNT,   8'h00, 16'h0000, 7'd0);
    send_op(OP_RESTORE, 8'h00, 16'h0000, 7'd64);
    send_op(OP_FIND,    pick_letter(), 16'h0000, 7'd0);
    send_op(OP_HIDE,    8'h00, 16'h0000, 7'd0);
    send_op(OP_UNHIDE,  8'h00, 16'h0000, 7'd0);
    send_op(OP_COUNT,   8'h00, 16'h0000, 7'd0);
    send_op(OP_FIND,    pick_letter(), 16'h0000, 7'd0);
  endtask

  // Nested scopes with random content; marks mostly come from earlier saves and hides
  task automatic test_random_scopes(input int n_items);
    int                roll;
    logic [MARK_W-1:0] m;
    for (int k = 0; k < n_items; k++) begin
      steady = (k >= n_items / 3) && (k < n_items / 3 + 300);
      roll   = $urandom_range(0, 99);
      if (roll < 32) begin
        send_op(OP_PUSH, pick_letter(), 16'($urandom), MARK_W'($urandom));
      end else if (roll < 62) begin
        send_op(OP_FIND, pick_letter(), 16'($urandom), MARK_W'($urandom));
      end else if (roll < 68) begin
        saved_tops.push_back(scope_top[MARK_W-1:0]);
        if (saved_tops.size() > 8) void'(saved_tops.pop_front());
        send_op(OP_SAVE, 8'($urandom), 16'($urandom), MARK_W'($urandom));
      end else if (roll < 74) begin
        if (saved_tops.size() > 0 && $urandom_range(0, 9) < 7) m = saved_tops.pop_back();
        else m = pick_mark();
        send_op(OP_RESTORE, 8'($urandom), 16'($urandom), m);
      end else if (roll < 80) begin
        hidden_bases.push_back(scope_base[MARK_W-1:0]);
        if (hidden_bases.size() > 8) void'(hidden_bases.pop_front());
        send_op(OP_HIDE, 8'($urandom), 16'($urandom), MARK_W'($urandom));
      end else if (roll < 86) begin
        if (hidden_bases.size() > 0 && $urandom_range(0, 9) < 7) m = hidden_bases.pop_back();
        else m = pick_mark();
        send_op(OP_UNHIDE, 8'($urandom), 16'($urandom), m);
      end else if (roll < 90) begin
        saved_tops.delete();
        hidden_bases.delete();
        send_op(OP_REWIND, 8'($urandom), 16'($urandom), MARK_W'($urandom));
      end else begin
        send_op(OP_COUNT, 8'($urandom), 16'($urandom), MARK_W'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // Intern new letters until the cache is full, then try one more
  task automatic test_cache_overflow();
    send_op(OP_REWIND, 8'h00, 16'h0000, 7'd0);
    while (slots_taken < CACHE_SLOTS && scope_top < STACK_DEPTH)
      send_op(OP_PUSH, fresh_letter(), 16'($urandom), 7'd0);
    send_op(OP_PUSH,  fresh_letter(), 16'hA5A5, 7'd0);
    send_op(OP_PUSH,  letter_of_slot[CACHE_SLOTS-1], 16'h5A5A, 7'd0);
    send_op(OP_FIND,  letter_of_slot[0], 16'h0000, 7'd0);
    send_op(OP_COUNT, 8'h00, 16'h0000, 7'd0);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_item       <= '0;
    out_ready     <= 1'b0;
    steady        = 1'b0;
    cycle_count   = 0;
    err_count     = 0;
    slots_taken   = 0;
    scope_base    = 0;
    scope_top     = 0;
    scope_written = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_scope_basics();
    test_stack_overflow();
    test_random_scopes(1250);
    test_cache_overflow();

    in_valid <= 1'b0;
    while (symbol_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sss_pkg.sv
rtl/scoped_symbol_stack_top.sv
rtl/sss_checker.sv
test/tb_scoped_symbol_stack_top.sv
